FILE: hdl/sifd_pkg.sv
`default_nettype none

package sifd_pkg;

  localparam int IMAGE_WIDTH  = 80;
  localparam int IMAGE_HEIGHT = 64;
  localparam int PACKED_BYTES = 7680;

  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 12;
  localparam int ADDR_W   = 13;
  localparam int POS_W    = 13;
  localparam int CNT_W    = 7;
  localparam int CRC_W    = 32;
  localparam int LANES    = 4;
  localparam int GROUP_W  = 3;
  localparam int LANE_W   = 2;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_W-1:0] PACK_START   = POS_W'(8);
  localparam logic [POS_W-1:0] TRAIL_START  = POS_W'(8 + PACKED_BYTES);
  localparam logic [POS_W-1:0] TRAIL_END    = POS_W'(12 + PACKED_BYTES);
  localparam logic [POS_W-1:0] LAST_POS     = POS_W'(12 + PACKED_BYTES);
  localparam logic [POS_W-1:0] TOTAL_LEN    = POS_W'(13 + PACKED_BYTES);
  localparam logic [POS_W-1:0] LAST_SUM_POS = POS_W'(11 + PACKED_BYTES);
  localparam logic [15:0]      DATA_LEN     = 16'(PACKED_BYTES + 10);
  localparam logic [BYTE_W-1:0] SUM_INIT    = BYTE_W'(PACKED_BYTES + 10);

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04c1_1db7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hffff_ffff;

  localparam logic [BYTE_W-1:0] SUM_TARGET  = 8'haa;
  localparam logic [BYTE_W-1:0] SUM_WAIVE   = 8'h88;
  localparam logic [BYTE_W-1:0] BAD_FIRST   = 8'haa;
  localparam logic [3:0]        CLASS_NIBBLE = 4'h2;

  localparam logic [GROUP_W-1:0] GROUP_LAST = GROUP_W'(5);
  localparam logic [LANE_W-1:0]  LANE_LAST  = LANE_W'(LANES - 1);
  localparam logic [CNT_W:0]     ROW_LIMIT  = (CNT_W + 1)'(IMAGE_HEIGHT);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHAPE    = 3'd1,
    ST_CLASS    = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_CRC      = 3'd4
  } sifd_status_t;

  typedef struct packed {
    logic                                is_status;
    logic [LANES-1:0][SAMPLE_W-1:0]      samples;
    sifd_status_t                        code;
    logic                                skipped;
  } sifd_job_t;

  typedef struct packed {
    logic      empty;
    sifd_job_t head;
  } sifd_qhead_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sifd_in_if.sv
`default_nettype none

interface sifd_in_if;
  import sifd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/sifd_out_if.sv
`default_nettype none

interface sifd_out_if;
  import sifd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic [ADDR_W-1:0]   pixel_address;
  logic                is_status;
  logic [2:0]          frame_status;
  logic                checksum_skipped;
  logic                result_last;

  modport source (output valid, output sample_value, output pixel_address,
                  output is_status, output frame_status, output checksum_skipped,
                  output result_last, input ready);
  modport sink   (input valid, input sample_value, input pixel_address,
                  input is_status, input frame_status, input checksum_skipped,
                  input result_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sensor_image_frame_decoder_core.sv
// Decodes one byte of a packed 12-bit image frame per transfer and returns four
// raster-addressed samples per six packed bytes, then one status result on the byte
// flagged frame_end (ok, shape, class, checksum or CRC). Input ready falls only while
// the queue is full, which a stalled result side causes; else a byte is taken every
// cycle: header checks, the CRC-32/MPEG-2 update and the additive sum run in the front
// stage in the cycle of the transfer, and each finished sample group or status goes
// into an eight-entry queue. The back stage drains the queue at one result per cycle
// unless the output stalls, through an output register that a result reaches after its
// queue entry; a sample group leaves as four results, a status as one. Samples leave
// before the frame is verified: commit them only on status ok.
`default_nettype none

module sensor_image_frame_decoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  sifd_in_if.sink   in_ch,
  sifd_out_if.source out_ch
);
  import sifd_pkg::*;

  logic        push;
  sifd_job_t   push_job;
  logic        full;
  logic        pop;
  sifd_qhead_t qhead;

  sifd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (full),
    .push       (push),
    .push_job   (push_job)
  );

  sifd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .qhead    (qhead)
  );

  sifd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qhead  (qhead),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: hdl/sifd_front.sv
`default_nettype none

module sifd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sifd_in_if.sink            in_ch,
  input  wire logic          queue_full,
  output logic               push,
  output sifd_pkg::sifd_job_t push_job
);
  import sifd_pkg::*;

  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [CRC_W-1:0]   crc_r,    crc_nxt;
  logic [BYTE_W-1:0]  sum_r,    sum_nxt;
  logic [BYTE_W-1:0]  len_lo_r, len_lo_nxt;
  sifd_status_t       err_r,    err_nxt;
  logic [GROUP_W-1:0] gidx_r,   gidx_nxt;
  logic [BYTE_W-1:0]  grp_r [5];
  logic [BYTE_W-1:0]  grp_nxt [5];
  logic [BYTE_W-1:0]  trl_r [4];
  logic [BYTE_W-1:0]  trl_nxt [4];

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [CRC_W-1:0]  seen;
  logic              waived;
  logic [POS_W-1:0]  trl_off;

  function automatic sifd_status_t note(input sifd_status_t cur, input sifd_status_t code);
    return (cur == ST_OK || code < cur) ? code : cur;
  endfunction

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && !queue_full;
  assign b           = in_ch.frame_byte;
  assign seen        = {trl_r[2], trl_r[3], trl_r[0], trl_r[1]};
  assign waived      = (b == SUM_WAIVE);
  assign trl_off     = pos_r - TRAIL_START;

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    sum_nxt    = sum_r;
    len_lo_nxt = len_lo_r;
    err_nxt    = err_r;
    gidx_nxt   = gidx_r;
    grp_nxt    = grp_r;
    trl_nxt    = trl_r;
    push       = 1'b0;
    push_job   = '0;
    if (accept) begin
      if (in_ch.frame_end) begin
        push               = 1'b1;
        push_job.is_status = 1'b1;
        if (pos_r != LAST_POS) begin
          push_job.code = ST_SHAPE;
        end else if (err_r != ST_OK) begin
          push_job.code = err_r;
        end else if (!waived && b != SUM_TARGET - sum_r) begin
          push_job.code = ST_CHECKSUM;
        end else begin
          push_job.code    = (seen == crc_r) ? ST_OK : ST_CRC;
          push_job.skipped = waived;
        end
        pos_nxt    = '0;
        crc_nxt    = CRC_INIT;
        sum_nxt    = SUM_INIT;
        len_lo_nxt = '0;
        err_nxt    = ST_OK;
        gidx_nxt   = '0;
      end else begin
        if (pos_r == POS_W'(0)) begin
          if (b[7:4] != CLASS_NIBBLE) err_nxt = note(err_r, ST_CLASS);
          sum_nxt = sum_r + b;
        end else if (pos_r == POS_W'(1)) begin
          len_lo_nxt = b;
        end else if (pos_r == POS_W'(2)) begin
          if ({b, len_lo_r} != DATA_LEN) err_nxt = note(err_r, ST_SHAPE);
        end
        if (pos_r >= POS_W'(3) && pos_r <= LAST_SUM_POS) sum_nxt = sum_r + b;
        if (pos_r == POS_W'(3) && b == BAD_FIRST) err_nxt = note(err_r, ST_CLASS);
        if (pos_r >= PACK_START && pos_r < TRAIL_START) begin
          crc_nxt = crc_byte(crc_r, b);
          if (gidx_r == GROUP_LAST) begin
            gidx_nxt         = '0;
            push             = 1'b1;
            push_job.samples[0] = {grp_r[0][3:0], grp_r[1]};
            push_job.samples[1] = {grp_r[3], grp_r[0][7:4]};
            push_job.samples[2] = {b[3:0], grp_r[2]};
            push_job.samples[3] = {grp_r[4], b[7:4]};
          end else begin
            grp_nxt[gidx_r] = b;
            gidx_nxt        = gidx_r + GROUP_W'(1);
          end
        end else if (pos_r >= TRAIL_START && pos_r < TRAIL_END) begin
          trl_nxt[trl_off[1:0]] = b;
        end
        if (pos_r < TOTAL_LEN) pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      sum_r    <= SUM_INIT;
      len_lo_r <= '0;
      err_r    <= ST_OK;
      gidx_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      sum_r    <= sum_nxt;
      len_lo_r <= len_lo_nxt;
      err_r    <= err_nxt;
      gidx_r   <= gidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    trl_r <= trl_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/sifd_queue.sv
`default_nettype none

module sifd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sifd_pkg::sifd_job_t push_job,
  output logic                     full,
  input  wire logic                pop,
  output sifd_pkg::sifd_qhead_t    qhead
);
  import sifd_pkg::*;

  sifd_job_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r,  count_nxt;
  logic               do_pop;

  assign full        = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign qhead.empty = (count_r == '0);
  assign qhead.head  = mem[rd_ptr_r];
  assign do_pop      = pop && !qhead.empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: hdl/sifd_back.sv
`default_nettype none

module sifd_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sifd_pkg::sifd_qhead_t qhead,
  output logic                       pop,
  sifd_out_if.source                 out_ch
);
  import sifd_pkg::*;

  logic                valid_r,  valid_nxt;
  logic [SAMPLE_W-1:0] value_r,  value_nxt;
  logic [ADDR_W-1:0]   addr_r,   addr_nxt;
  logic                stat_r,   stat_nxt;
  sifd_status_t        code_r,   code_nxt;
  logic                skip_r,   skip_nxt;
  logic                last_r,   last_nxt;
  logic [LANE_W-1:0]   lane_r,   lane_nxt;
  logic [CNT_W-1:0]    row_r,    row_nxt;
  logic [CNT_W-1:0]    col_r,    col_nxt;

  logic                load;
  logic [CNT_W-1:0]    row_inc;
  logic [ADDR_W:0]     addr_full;

  assign load      = !qhead.empty && (!valid_r || out_ch.ready);
  assign row_inc   = row_r + CNT_W'(1);
  assign addr_full = (ADDR_W + 1)'(row_r) * (ADDR_W + 1)'(IMAGE_WIDTH)
                   + (ADDR_W + 1)'(col_r);

  always_comb begin
    valid_nxt = valid_r && !out_ch.ready;
    value_nxt = value_r;
    addr_nxt  = addr_r;
    stat_nxt  = stat_r;
    code_nxt  = code_r;
    skip_nxt  = skip_r;
    last_nxt  = last_r;
    lane_nxt  = lane_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (qhead.head.is_status) begin
        value_nxt = '0;
        addr_nxt  = '0;
        stat_nxt  = 1'b1;
        code_nxt  = qhead.head.code;
        skip_nxt  = qhead.head.skipped;
        last_nxt  = 1'b1;
        lane_nxt  = '0;
        row_nxt   = '0;
        col_nxt   = '0;
        pop       = 1'b1;
      end else begin
        value_nxt = qhead.head.samples[lane_r];
        addr_nxt  = addr_full[ADDR_W-1:0];
        stat_nxt  = 1'b0;
        code_nxt  = ST_OK;
        skip_nxt  = 1'b0;
        last_nxt  = (lane_r == LANE_LAST);
        pop       = (lane_r == LANE_LAST);
        lane_nxt  = lane_r + LANE_W'(1);
        if ({1'b0, row_inc} == ROW_LIMIT) begin
          row_nxt = '0;
          col_nxt = col_r + CNT_W'(1);
        end else begin
          row_nxt = row_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lane_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      lane_r  <= lane_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    addr_r  <= addr_nxt;
    stat_r  <= stat_nxt;
    code_r  <= code_nxt;
    skip_r  <= skip_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.sample_value     = value_r;
  assign out_ch.pixel_address    = addr_r;
  assign out_ch.is_status        = stat_r;
  assign out_ch.frame_status     = code_r;
  assign out_ch.checksum_skipped = skip_r;
  assign out_ch.result_last      = last_r;

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && stat_r) |-> last_r) else $error("status not marked last");

  a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && qhead.head.is_status) |=> (row_r == '0 && col_r == '0 && lane_r == '0))
    else $error("raster counters not cleared at frame end");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> last_r && valid_r) else $error("job retired without a last result");

endmodule

`default_nettype wire

FILE: sim/tb_sensor_image_frame_decoder_core.sv
`timescale 1ns / 100ps

module tb_sensor_image_frame_decoder_core;
  import sifd_pkg::*;

  localparam int FRAME_LEN   = PACKED_BYTES + 13;
  localparam int FRAME_LAST  = PACKED_BYTES + 12;
  localparam int PIX_FIRST   = 8;
  localparam int TRAIL_FIRST = PIX_FIRST + PACKED_BYTES;
  localparam logic [15:0] LEN_FIELD  = 16'(PACKED_BYTES + 10);
  localparam logic [31:0] MPEG2_POLY = 32'h04c1_1db7;
  localparam logic [31:0] MPEG2_SEED = 32'hffff_ffff;
  localparam logic [7:0]  WAIVE_BYTE = 8'h88;
  localparam logic [7:0]  SUM_GOAL   = 8'haa;
  localparam logic [7:0]  NO_LEAD    = 8'haa;
  localparam logic [3:0]  CLASS_HI   = 4'h2;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int REPORT_MAX  = 10;

  typedef logic [4:0] flaw_set_t;
  localparam flaw_set_t NO_FLAW      = 5'b00000;
  localparam flaw_set_t BAD_CLASS    = 5'b00001;
  localparam flaw_set_t BAD_LEAD     = 5'b00010;
  localparam flaw_set_t BAD_LENGTH   = 5'b00100;
  localparam flaw_set_t BAD_CHECKSUM = 5'b01000;
  localparam flaw_set_t BAD_CRC      = 5'b10000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]   addr;
    logic                is_status;
    sifd_status_t        status;
    logic                skipped;
    logic                last;
  } pixel_result_t;

  logic clk;
  logic rst_n;

  sifd_in_if  in_ch ();
  sifd_out_if out_ch ();

  sensor_image_frame_decoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int           dec_pos;
  logic [31:0]  dec_crc;
  logic [7:0]   dec_sum;
  logic [7:0]   dec_group [5];
  logic [7:0]   dec_trail [4];
  logic [7:0]   dec_len_lo;
  sifd_status_t dec_err;
  logic [6:0]   dec_row;
  logic [6:0]   dec_col;

  pixel_result_t decoded_q [$];
  pixel_result_t got_r;
  pixel_result_t want_r;

  int cycles = 0;
  int fault_count = 0;
  int bytes_in = 0;
  int frames_in = 0;
  int samples_checked = 0;
  int statuses_checked = 0;
  int status_hits [5] = '{default: 0};
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] mpeg2_crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      fb = c[31];
      c  = {c[30:0], 1'b0};
      if (fb) c = c ^ MPEG2_POLY;
    end
    return c;
  endfunction

  function automatic void clear_decoder();
    dec_pos    = 0;
    dec_crc    = MPEG2_SEED;
    dec_sum    = LEN_FIELD[7:0];
    dec_len_lo = '0;
    dec_err    = ST_OK;
    dec_row    = '0;
    dec_col    = '0;
    for (int i = 0; i < 5; i++) dec_group[i] = '0;
    for (int i = 0; i < 4; i++) dec_trail[i] = '0;
  endfunction

  function automatic void note_flaw(sifd_status_t code);
    if (dec_err == ST_OK || code < dec_err) dec_err = code;
  endfunction

  function automatic void push_pixel(logic [SAMPLE_W-1:0] v, logic last);
    pixel_result_t r;
    r        = '0;
    r.sample = v;
    r.addr   = ADDR_W'(dec_row * IMAGE_WIDTH + dec_col);
    r.status = ST_OK;
    r.last   = last;
    decoded_q.push_back(r);
    dec_row = dec_row + 7'd1;
    if (dec_row == 7'(IMAGE_HEIGHT)) begin
      dec_row = '0;
      dec_col = dec_col + 7'd1;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic e);
    pixel_result_t r;
    logic [31:0]   seen;
    int            k;
    if (e) begin
      r           = '0;
      r.is_status = 1'b1;
      r.last      = 1'b1;
      if (dec_pos != FRAME_LAST) r.status = ST_SHAPE;
      else if (dec_err != ST_OK) r.status = dec_err;
      else if (b != WAIVE_BYTE && b != SUM_GOAL - dec_sum) r.status = ST_CHECKSUM;
      else begin
        seen      = {dec_trail[2], dec_trail[3], dec_trail[0], dec_trail[1]};
        r.status  = (seen == dec_crc) ? ST_OK : ST_CRC;
        r.skipped = (b == WAIVE_BYTE);
      end
      decoded_q.push_back(r);
      status_hits[r.status]++;
      clear_decoder();
      return;
    end
    if (dec_pos == 0) begin
      if (b[7:4] != CLASS_HI) note_flaw(ST_CLASS);
      dec_sum = dec_sum + b;
    end else if (dec_pos == 1) begin
      dec_len_lo = b;
    end else if (dec_pos == 2) begin
      if ({b, dec_len_lo} != LEN_FIELD) note_flaw(ST_SHAPE);
    end
    if (dec_pos >= 3 && dec_pos + 2 <= FRAME_LEN) dec_sum = dec_sum + b;
    if (dec_pos == 3 && b == NO_LEAD) note_flaw(ST_CLASS);
    if (dec_pos >= PIX_FIRST && dec_pos < TRAIL_FIRST) begin
      dec_crc = mpeg2_crc_byte(dec_crc, b);
      k = (dec_pos - PIX_FIRST) % 6;
      if (k < 5) begin
        dec_group[k] = b;
      end else begin
        push_pixel({dec_group[0][3:0], dec_group[1]}, 1'b0);
        push_pixel({dec_group[3], dec_group[0][7:4]}, 1'b0);
        push_pixel({b[3:0], dec_group[2]}, 1'b0);
        push_pixel({dec_group[4], b[7:4]}, 1'b1);
      end
    end else if (dec_pos >= TRAIL_FIRST && dec_pos < TRAIL_FIRST + 4) begin
      dec_trail[dec_pos - TRAIL_FIRST] = b;
    end
    if (dec_pos < FRAME_LEN) dec_pos++;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.frame_end  <= e;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, e);
    bytes_in++;
    if (e) frames_in++;
  endtask

  task automatic send_frame(input flaw_set_t flaws, input logic waive, input int end_pos);
    logic [7:0]  b;
    logic [7:0]  good;
    logic [3:0]  hi;
    logic [31:0] crc_goal;
    crc_goal = '0;
    for (int p = 0; p <= end_pos; p++) begin
      b = 8'($urandom);
      if (p == 0) begin
        hi = CLASS_HI;
        if ((flaws & BAD_CLASS) != 0) begin
          hi = 4'($urandom_range(14));
          if (hi >= CLASS_HI) hi++;
        end
        b[7:4] = hi;
      end else if (p == 1) begin
        b = LEN_FIELD[7:0];
      end else if (p == 2) begin
        b = LEN_FIELD[15:8];
        if ((flaws & BAD_LENGTH) != 0) b = b ^ 8'($urandom_range(1, 255));
      end else if (p == 3) begin
        if ((flaws & BAD_LEAD) != 0) b = NO_LEAD;
        else if (b == NO_LEAD) b = ~b;
      end else if (p == TRAIL_FIRST) begin
        crc_goal = dec_crc;
        if ((flaws & BAD_CRC) != 0) crc_goal = crc_goal ^ (32'h1 << $urandom_range(31));
        b = crc_goal[15:8];
      end else if (p == TRAIL_FIRST + 1) begin
        b = crc_goal[7:0];
      end else if (p == TRAIL_FIRST + 2) begin
        b = crc_goal[31:24];
      end else if (p == TRAIL_FIRST + 3) begin
        b = crc_goal[23:16];
      end else if (p == FRAME_LAST) begin
        good = SUM_GOAL - dec_sum;
        if ((flaws & BAD_CHECKSUM) != 0) begin
          while (b == good || b == WAIVE_BYTE) b = 8'($urandom);
        end else begin
          b = waive ? WAIVE_BYTE : good;
        end
      end
      send_byte(b, p == end_pos);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 1; i <= n; i++) send_byte(8'($urandom), i == n || $urandom_range(19) == 0);
  endtask

  task automatic test_frame_shape();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_frame(BAD_CLASS, 1'b0, 5);
    send_frame(NO_FLAW, 1'b0, 13);
  endtask

  task automatic test_header_checks();
    send_frame(BAD_CLASS, 1'b0, 13);
    send_frame(BAD_LEAD | BAD_CRC, 1'b1, 13);
    send_frame(BAD_LENGTH | BAD_CLASS, 1'b0, 13);
    send_frame(BAD_CLASS | BAD_CHECKSUM, 1'b0, 13);
  endtask

  task automatic test_partial_groups();
    send_frame(NO_FLAW, 1'b0, 10);
    send_frame(NO_FLAW, 1'b1, 31);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    send_frame(flaw_set_t'($urandom_range(31)), 1'b0, $urandom_range(8, 19));
    send_noise($urandom_range(6, 10));
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_r.sample    = out_ch.sample_value;
      got_r.addr      = out_ch.pixel_address;
      got_r.is_status = out_ch.is_status;
      got_r.status    = sifd_status_t'(out_ch.frame_status);
      got_r.skipped   = out_ch.checksum_skipped;
      got_r.last      = out_ch.result_last;
      if (got_r.is_status) statuses_checked++;
      else samples_checked++;
      if (decoded_q.size() == 0) begin
        if (fault_count < REPORT_MAX)
          $display("cycle %0d: unexpected transfer, sample %h addr %0d status %0b/%0d",
                   cycles, got_r.sample, got_r.addr, got_r.is_status, got_r.status);
        fault_count++;
      end else begin
        want_r = decoded_q.pop_front();
        if (got_r !== want_r) begin
          if (fault_count < REPORT_MAX)
            $display({"cycle %0d: expected sample %h addr %0d status %0b/%0d skip %0b ",
                      "last %0b, got sample %h addr %0d status %0b/%0d skip %0b last %0b"},
                     cycles, want_r.sample, want_r.addr, want_r.is_status, want_r.status,
                     want_r.skipped, want_r.last, got_r.sample, got_r.addr,
                     got_r.is_status, got_r.status, got_r.skipped, got_r.last);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, decoded_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = '0;
    in_ch.frame_end  = 1'b0;
    out_ch.ready     = 1'b0;
    clear_decoder();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_frame_shape();
    test_header_checks();
    test_partial_groups();
    test_random_traffic(0, 0);
    test_random_traffic(48, 0);
    test_random_traffic(0, 48);
    test_random_traffic(22, 22);

    // drop valid, then drain
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d frames in %0d bytes over %0d cycles; checked %0d samples, %0d statuses",
             frames_in, bytes_in, cycles, samples_checked, statuses_checked);
    $display("Statuses ok %0d, shape %0d, class %0d, checksum %0d, crc %0d; %0d faults",
             status_hits[ST_OK], status_hits[ST_SHAPE], status_hits[ST_CLASS],
             status_hits[ST_CHECKSUM], status_hits[ST_CRC], fault_count);
    if (fault_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/sifd_pkg.sv
hdl/sifd_in_if.sv
hdl/sifd_out_if.sv
hdl/sifd_front.sv
hdl/sifd_queue.sv
hdl/sifd_back.sv
hdl/sensor_image_frame_decoder_core.sv
sim/tb_sensor_image_frame_decoder_core.sv
